// ----- rtl/core/snbc_pkg.sv -----
// Shared types, widths and codes for the signature norm bound check.
// Used by every module under rtl/core; depends on nothing.
package snbc_pkg;

	localparam int CoefW     = 50;  // signed coefficient / magnitude width
	localparam int ModW      = 49;  // modulus and centred residue width
	localparam int SumW      = 63;  // saturating sums, bounds
	localparam int ShiftW    = 6;
	localparam int DivSteps  = CoefW;  // one remainder bit per stage
	localparam int InDataW   = 56;
	localparam int OutDataW  = 8;
	localparam int ApbAddrW  = 5;
	localparam int ApbDataW  = 64;
	localparam int QDepth    = 4;
	localparam int QPtrW     = 2;
	localparam int QCntW     = 3;

	localparam logic [SumW-1:0]   Sat63          = '1;
	localparam logic [ModW-1:0]   ModMax         = '1;
	localparam logic [ModW-1:0]   ModQReset      = 49'd562948879679489;
	localparam logic [ShiftW-1:0] HintShiftReset = 6'd44;

	typedef enum logic [1:0] {
		REG_MODULUS_Q  = 2'd0,
		REG_INF_BOUND  = 2'd1,
		REG_HINT_SHIFT = 2'd2,
		REG_L2_BOUND   = 2'd3
	} snbc_reg_t;

	typedef enum logic [1:0] {
		FAIL_NONE     = 2'd0,
		FAIL_HINT_INF = 2'd1,
		FAIL_RESP_INF = 2'd2,
		FAIL_L2       = 2'd3
	} snbc_fail_t;

	// classified coefficient as it travels front to back
	typedef struct packed {
		logic             kind;  // 0 hint, 1 response
		logic             last;
		logic             neg;
		logic [CoefW-1:0] mag;   // |coeff|, up to 2^49
	} snbc_item_t;

	// configuration and values derived from it
	typedef struct packed {
		logic [ModW-1:0]  mod_q;
		logic [ModW-1:0]  inf_bound;
		logic [SumW-1:0]  l2_bound;
		logic [CoefW-1:0] hint_bound;
		logic             left_mode;  // hint_shift >= 32
		logic [5:0]       lsh;        // 2s - 64
		logic [6:0]       rsh;        // 64 - 2s
		logic [SumW-1:0]  lim;        // largest sum that survives lsh
	} snbc_cfg_t;

endpackage

// ----- rtl/core/signature_norm_bound_check.sv -----
// Top level of the signature norm bound check.
// Depends on snbc_pkg, snbc_cfg, snbc_front, snbc_queue, snbc_back.
//
// Coefficients stream in on the s_ side, one transaction per coefficient,
// tagged by s_tuser as hint (0) or response (1); s_tlast closes a signature.
// Throughput is one coefficient per clock while the m_ side does not stall.
// From acceptance a coefficient passes the 4-entry input queue, then the
// 50 restoring remainder stages (one bit of |coeff| mod q per stage),
// centring (2), squaring on one 32x32 multiplier, accumulation, and two
// verdict stages into the output register, where its verdict sits.
// A verdict
// (pass, fail_code) leaves on the m_ side only for a coefficient marked last;
// the accumulators then restart from zero. fail_code reports the first
// broken bound: hint infinity, response infinity, then the scaled L2 sum.
// A stalled m_ side stalls the back pipeline; the queue absorbs up to four
// more coefficients before s_tready drops. Registers (modulus_q at 0x00,
// inf_bound at 0x08, hint_shift at 0x10, l2_bound at 0x18) are written over
// APB with no wait states, and must only be changed while no signature is
// in flight. There is no clearing pass after reset.
module signature_norm_bound_check
	import snbc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // [49:0] coeff_value, rest zero
	input  logic [0:0]          s_tuser,   // [0] kind
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // [0] pass, [2:1] fail_code, rest zero
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	snbc_cfg_t  cfg;
	snbc_item_t push_item;
	snbc_item_t pop_item;
	logic       push_valid;
	logic       push_ready;
	logic       pop_valid;
	logic       pop_ready;
	snbc_fail_t code;

	assign pready = 1'b1;

	snbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// front: magnitude and classification, straight into the queue
	snbc_front u_front (
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_coeff   (s_tdata[CoefW-1:0]),
		.in_kind    (s_tuser[0]),
		.in_last    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	snbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_item  (push_item),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_item  (pop_item)
	);

	snbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (pop_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_code   (code)
	);

	// pass is simply "no bound broken"
	assign m_tdata = {5'd0, code, (code == FAIL_NONE)};

endmodule

// ----- rtl/core/snbc_cfg.sv -----
// APB register file and derived bound/scaling values.
// Depends on snbc_pkg.
module snbc_cfg
	import snbc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output snbc_cfg_t           cfg
);

	logic [ModW-1:0]   mod_q_q;
	logic [ModW-1:0]   inf_bound_q;
	logic [ShiftW-1:0] hint_shift_q;
	logic [SumW-1:0]   l2_bound_q;

	logic [CoefW-1:0]  hint_bound_q;
	logic              left_mode_q;
	logic [5:0]        lsh_q;
	logic [6:0]        rsh_q;
	logic [SumW-1:0]   lim_q;

	logic              wr_en;
	snbc_reg_t         reg_sel;
	logic [63:0]       round_c;
	logic [63:0]       bound_sum;
	logic [63:0]       bound_shr;
	logic [5:0]        lsh_nxt;

	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = snbc_reg_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q_q      <= ModQReset;
			inf_bound_q  <= '0;
			hint_shift_q <= HintShiftReset;
			l2_bound_q   <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MODULUS_Q:  mod_q_q      <= pwdata[ModW-1:0];
				REG_INF_BOUND:  inf_bound_q  <= pwdata[ModW-1:0];
				REG_HINT_SHIFT: hint_shift_q <= pwdata[ShiftW-1:0];
				REG_L2_BOUND:   l2_bound_q   <= pwdata[SumW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MODULUS_Q:  prdata = {{(ApbDataW-ModW){1'b0}}, mod_q_q};
			REG_INF_BOUND:  prdata = {{(ApbDataW-ModW){1'b0}}, inf_bound_q};
			REG_HINT_SHIFT: prdata = {{(ApbDataW-ShiftW){1'b0}}, hint_shift_q};
			REG_L2_BOUND:   prdata = {{(ApbDataW-SumW){1'b0}}, l2_bound_q};
			default:        prdata = '0;
		endcase
	end

	// hint bound = (inf_bound + 2^(s-1)) >> s; result always below 2^49
	assign round_c   = (hint_shift_q == '0) ? 64'd0 : (64'd1 << (hint_shift_q - 6'd1));
	assign bound_sum = {{(64-ModW){1'b0}}, inf_bound_q} + round_c;
	assign bound_shr = bound_sum >> hint_shift_q;
	assign lsh_nxt   = {hint_shift_q[4:0], 1'b0};

	// derived values are registered, settling in the cycle after a write; items take far longer to reach them
	always_ff @(posedge clk) begin
		hint_bound_q <= bound_shr[CoefW-1:0];
		left_mode_q  <= hint_shift_q[5];
		lsh_q        <= lsh_nxt;
		rsh_q        <= 7'd64 - {1'b0, lsh_nxt};
		lim_q        <= Sat63 >> lsh_nxt;
	end

	always_comb begin
		cfg.mod_q      = mod_q_q;
		cfg.inf_bound  = inf_bound_q;
		cfg.l2_bound   = l2_bound_q;
		cfg.hint_bound = hint_bound_q;
		cfg.left_mode  = left_mode_q;
		cfg.lsh        = lsh_q;
		cfg.rsh        = rsh_q;
		cfg.lim        = lim_q;
	end

endmodule

// ----- rtl/core/snbc_front.sv -----
// Front end: accepts coefficients, takes the magnitude and classifies them.
// Depends on snbc_pkg.
module snbc_front
	import snbc_pkg::*;
(
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CoefW-1:0]   in_coeff,
	input  logic               in_kind,
	input  logic               in_last,
	output logic               push_valid,
	input  logic               push_ready,
	output snbc_item_t         push_item
);

	logic             neg;
	logic [CoefW-1:0] mag;

	assign neg = in_coeff[CoefW-1];
	// most negative value maps to 2^49, still fits unsigned
	assign mag = neg ? (~in_coeff + {{(CoefW-1){1'b0}}, 1'b1}) : in_coeff;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		push_item.kind = in_kind;
		push_item.last = in_last;
		push_item.neg  = neg;
		push_item.mag  = mag;
	end

endmodule

// ----- rtl/core/snbc_queue.sv -----
// Short FIFO of classified items between front and back.
// Depends on snbc_pkg.
module snbc_queue
	import snbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  snbc_item_t wr_item,
	output logic       rd_valid,
	input  logic       rd_ready,
	output snbc_item_t rd_item
);

	snbc_item_t        mem [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0]  count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != QCntW'(QDepth));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;
	assign rd_item  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wr_item;
	end

endmodule

// ----- rtl/core/snbc_back.sv -----
// Back end: pipelined mod-q remainder, centring, squaring, accumulation
// and verdict with output register. Depends on snbc_pkg.
module snbc_back
	import snbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  snbc_cfg_t  cfg,
	input  logic       item_valid,
	output logic       item_ready,
	input  snbc_item_t item,
	output logic       out_valid,
	input  logic       out_ready,
	output snbc_fail_t out_code
);

	function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
		input logic [SumW-1:0] b);
		logic [SumW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SumW] ? Sat63 : s[SumW-1:0];
	endfunction

	logic advance;

	// restoring remainder stages, stage k resolves magnitude bit CoefW-1-k
	logic [DivSteps-1:0] vld_s;
	logic [ModW-1:0]     rem_s   [DivSteps];
	snbc_item_t          item_s  [DivSteps];
	logic [ModW-1:0]     rem_in  [DivSteps];
	snbc_item_t          item_in [DivSteps];
	logic [ModW-1:0]     rem_nxt [DivSteps];
	logic [ModW:0]       trial   [DivSteps];

	// centring, squaring, accumulation, verdict
	logic             vld_s51, vld_s52, vld_s53, vld_s55, vld_s56;
	snbc_item_t       item_s51;
	logic [ModW-1:0]  r1_s51;
	logic             kind_s52, last_s52, big_s52;
	logic [CoefW-1:0] val_s52;
	logic             kind_s53, last_s53, big_s53;
	logic [CoefW-1:0] val_s53;
	logic [63:0]      prod_s53;
	logic [CoefW-1:0] hmax_q;
	logic [ModW-1:0]  rmax_q;
	logic [SumW-1:0]  hsum_q, rsum_q;
	logic [CoefW-1:0] hmax_s55;
	logic [ModW-1:0]  rmax_s55;
	logic [SumW-1:0]  hsum_s55, rsum_s55;
	logic             fh_s56, fr_s56;
	logic [SumW-1:0]  scaled_s56, rsum_s56;
	logic             out_vld_q;
	snbc_fail_t       out_code_q;

	logic [ModW-1:0]  rem_last;
	logic [ModW-1:0]  r1_nxt;
	logic [ModW-1:0]  x_resp;
	logic [CoefW-1:0] val_nxt;
	logic [31:0]      mul_a;
	logic [SumW-1:0]  sq;
	logic [CoefW-1:0] hmax_n;
	logic [ModW-1:0]  rmax_n;
	logic [SumW-1:0]  hsum_n, rsum_n;
	logic [SumW-1:0]  scaled_nxt;
	logic [SumW-1:0]  total;
	snbc_fail_t       code_nxt;

	assign advance    = ~out_vld_q | out_ready;
	assign item_ready = advance;

	always_comb begin
		rem_in[0]  = '0;
		item_in[0] = item;
		for (int k = 1; k < DivSteps; k++) begin
			rem_in[k]  = rem_s[k-1];
			item_in[k] = item_s[k-1];
		end
		for (int k = 0; k < DivSteps; k++) begin
			trial[k]   = {rem_in[k], item_in[k].mag[CoefW-1-k]};
			rem_nxt[k] = (trial[k] >= {1'b0, cfg.mod_q})
				? ModW'(trial[k] - {1'b0, cfg.mod_q}) : trial[k][ModW-1:0];
		end
	end

	// centring: negate residue for negative input, then fold above q/2
	assign rem_last = rem_s[DivSteps-1];
	assign r1_nxt   = (item_s[DivSteps-1].neg && rem_last != '0)
		? (cfg.mod_q - rem_last) : rem_last;

	always_comb begin
		if (cfg.mod_q == '0)
			x_resp = item_s51.mag[CoefW-1] ? ModMax : item_s51.mag[ModW-1:0];
		else if (r1_s51 > (cfg.mod_q >> 1))
			x_resp = cfg.mod_q - r1_s51;
		else
			x_resp = r1_s51;
		val_nxt = item_s51.kind ? {1'b0, x_resp} : item_s51.mag;
	end

	// response squares use bits 48 to 32 only
	assign mul_a = kind_s52 ? {15'd0, val_s52[ModW-1:32]} : val_s52[31:0];

	always_comb begin
		sq = (!kind_s53 && (big_s53 || prod_s53[63])) ? Sat63 : prod_s53[SumW-1:0];
		hmax_n = hmax_q;
		hsum_n = hsum_q;
		rmax_n = rmax_q;
		rsum_n = rsum_q;
		if (!kind_s53) begin
			if (val_s53 > hmax_q) hmax_n = val_s53;
			hsum_n = sat_add(hsum_q, sq);
		end else begin
			if (val_s53[ModW-1:0] > rmax_q) rmax_n = val_s53[ModW-1:0];
			rsum_n = sat_add(rsum_q, sq);
		end
	end

	always_comb begin
		if (cfg.left_mode)
			scaled_nxt = (hsum_s55 > cfg.lim) ? Sat63 : (hsum_s55 << cfg.lsh);
		else
			scaled_nxt = SumW'({1'b0, hsum_s55} >> cfg.rsh);
	end

	assign total = sat_add(scaled_s56, rsum_s56);

	always_comb begin
		if (fh_s56)
			code_nxt = FAIL_HINT_INF;
		else if (fr_s56)
			code_nxt = FAIL_RESP_INF;
		else if (total > cfg.l2_bound)
			code_nxt = FAIL_L2;
		else
			code_nxt = FAIL_NONE;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			vld_s51   <= 1'b0;
			vld_s52   <= 1'b0;
			vld_s53   <= 1'b0;
			vld_s55   <= 1'b0;
			vld_s56   <= 1'b0;
			out_vld_q <= 1'b0;
			hmax_q    <= '0;
			rmax_q    <= '0;
			hsum_q    <= '0;
			rsum_q    <= '0;
		end else if (advance) begin
			vld_s     <= {vld_s[DivSteps-2:0], item_valid};
			vld_s51   <= vld_s[DivSteps-1];
			vld_s52   <= vld_s51;
			vld_s53   <= vld_s52;
			vld_s55   <= vld_s53 & last_s53;
			vld_s56   <= vld_s55;
			out_vld_q <= vld_s56;
			if (vld_s53) begin
				if (last_s53) begin
					hmax_q <= '0;
					rmax_q <= '0;
					hsum_q <= '0;
					rsum_q <= '0;
				end else begin
					hmax_q <= hmax_n;
					rmax_q <= rmax_n;
					hsum_q <= hsum_n;
					rsum_q <= rsum_n;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < DivSteps; k++) begin
				rem_s[k]  <= rem_nxt[k];
				item_s[k] <= item_in[k];
			end
			item_s51   <= item_s[DivSteps-1];
			r1_s51     <= r1_nxt;
			kind_s52   <= item_s51.kind;
			last_s52   <= item_s51.last;
			big_s52    <= |item_s51.mag[CoefW-1:32];
			val_s52    <= val_nxt;
			kind_s53   <= kind_s52;
			last_s53   <= last_s52;
			big_s53    <= big_s52;
			val_s53    <= val_s52;
			prod_s53   <= mul_a * mul_a;
			hmax_s55   <= hmax_n;
			rmax_s55   <= rmax_n;
			hsum_s55   <= hsum_n;
			rsum_s55   <= rsum_n;
			fh_s56     <= (hmax_s55 > cfg.hint_bound);
			fr_s56     <= (rmax_s55 > cfg.inf_bound);
			scaled_s56 <= scaled_nxt;
			rsum_s56   <= rsum_s55;
			out_code_q <= code_nxt;
		end
	end

	assign out_valid = out_vld_q;
	assign out_code  = out_code_q;

endmodule

// ----- rtl/core/snbc_checker.sv -----
// Port-level checks for signature_norm_bound_check, bound to the top level.
// Depends on snbc_pkg.
module snbc_checker
	import snbc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic                pready
);

	// held verdict must not change while the sink stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("verdict changed under backpressure");

	a_pass_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == FAIL_NONE)))
		else $error("pass flag disagrees with fail code");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OutDataW-1:3] == '0))
		else $error("padding bits set in verdict");

	a_no_wait: assert property (@(posedge clk) pready)
		else $error("APB wait state inserted");

	// the output valid register is cleared by reset, so nothing can leave right after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("verdict right after reset");

endmodule

bind signature_norm_bound_check snbc_checker u_snbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
